/* rtl/ertm_pkg.sv */
// Package for the Euler-angle to rotation-matrix block.
// Holds the CORDIC arctangent table, value types and fixed constants.
// No dependencies.
package ertm_pkg;

   // CORDIC x/y in Q2.30 with headroom, z in 2^-32 turn units
   typedef logic signed [32:0] cxy_type;
   typedef logic signed [31:0] cz_type;
   // cosine or sine in Q20
   typedef logic signed [22:0] trig_type;
   // two-factor product in Q40
   typedef logic signed [45:0] prod_type;
   // sum in Q60
   typedef logic signed [67:0] q60_type;
   typedef logic signed [15:0] q14_type;

   localparam cxy_type INV_GAIN = 33'sh026DD3B6A;
   localparam cz_type EIGHTH_TURN = 32'sh20000000;
   localparam q14_type ONE_Q14 = 16'sd16384;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage

/* rtl/ertm_cordic_cell.sv */
// One CORDIC rotation cell: a single micro-rotation of x, y, z per cycle while adv is high.
// Uses ertm_pkg for types and the arctangent table.
module ertm_cordic_cell
   import ertm_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       adv,
   input  cxy_type    x_i,
   input  cxy_type    y_i,
   input  cz_type     z_i,
   input  logic [1:0] quad_i,
   output cxy_type    x_o,
   output cxy_type    y_o,
   output cz_type     z_o,
   output logic [1:0] quad_o
);

   localparam int K = STEP % 32;
   localparam cz_type ATAN = cz_type'(ATAN_TURNS[K]);

   cxy_type x_ff, x_in, y_ff, y_in;
   cz_type z_ff, z_in;
   logic [1:0] quad_ff;
   cxy_type dx, dy;

   always_comb begin
      dx = y_i >>> K;
      dy = x_i >>> K;
      if (z_i >= 0) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         quad_ff <= quad_i;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
   assign quad_o = quad_ff;

endmodule

/* rtl/ertm_matrix.sv */
// Quadrant mapping, products and Q1.14 rounding for the nine matrix entries.
// Five register stages; uses ertm_pkg for types and constants.
module ertm_matrix
   import ertm_pkg::*;
(
   input  logic       clock,
   input  logic       adv,
   input  cxy_type    x_i [3],
   input  cxy_type    y_i [3],
   input  logic [1:0] quad_i [3],
   output q14_type    r_o [9]
);

   function automatic q60_type wide(input logic signed [46:0] v, input int sh);
      q60_type w;
      w = q60_type'(v);
      return w <<< sh;
   endfunction

   function automatic q14_type to_q14(input q60_type v);
      q60_type s;
      logic signed [21:0] r;
      s = v + (q60_type'(1) <<< 45);
      r = s[67:46];
      if (r > 22'sd16384) return ONE_Q14;
      if (r < -22'sd16384) return -ONE_Q14;
      return q14_type'(r);
   endfunction

   // stage 0: cos/sin per angle (0 pitch, 1 roll, 2 yaw)
   trig_type cos_ff [3], sin_ff [3], cos_in [3], sin_in [3];
   // stage 1: pairwise products
   prod_type bd_ff, ad_ff, ce_ff, cf_ff, af_ff, ae_ff, bf_ff, be_ff, bc_ff, ac_ff;
   trig_type d_ff, e_ff, f_ff;
   // stage 2: split three-factor products
   logic signed [46:0] bdhe_ff, bdle_ff, bdhf_ff, bdlf_ff;
   logic signed [46:0] adhe_ff, adle_ff, adhf_ff, adlf_ff;
   prod_type ce2_ff, cf2_ff, af2_ff, ae2_ff, bf2_ff, be2_ff, bc2_ff, ac2_ff;
   trig_type d2_ff;
   // stage 3 and 4
   q60_type v_ff [9];
   q14_type r_ff [9];

   logic signed [23:0] bdh, adh;
   logic signed [22:0] bdl, adl;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cxy_type cr, sr;
         trig_type c, s;
         cr = x_i[a] + 33'sd512;
         sr = y_i[a] + 33'sd512;
         c = cr[32:10];
         s = sr[32:10];
         unique case (quad_i[a])
            2'd0: begin cos_in[a] = c;  sin_in[a] = s;  end
            2'd1: begin cos_in[a] = -s; sin_in[a] = c;  end
            2'd2: begin cos_in[a] = -c; sin_in[a] = -s; end
            default: begin cos_in[a] = s; sin_in[a] = -c; end
         endcase
      end
      bdh = bd_ff[45:22];
      bdl = {1'b0, bd_ff[21:0]};
      adh = ad_ff[45:22];
      adl = {1'b0, ad_ff[21:0]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         // A=cos pitch B=sin pitch C=cos roll D=sin roll E=cos yaw F=sin yaw
         bd_ff <= prod_type'(sin_ff[0] * sin_ff[1]);
         ad_ff <= prod_type'(cos_ff[0] * sin_ff[1]);
         ce_ff <= prod_type'(cos_ff[1] * cos_ff[2]);
         cf_ff <= prod_type'(cos_ff[1] * sin_ff[2]);
         af_ff <= prod_type'(cos_ff[0] * sin_ff[2]);
         ae_ff <= prod_type'(cos_ff[0] * cos_ff[2]);
         bf_ff <= prod_type'(sin_ff[0] * sin_ff[2]);
         be_ff <= prod_type'(sin_ff[0] * cos_ff[2]);
         bc_ff <= prod_type'(sin_ff[0] * cos_ff[1]);
         ac_ff <= prod_type'(cos_ff[0] * cos_ff[1]);
         d_ff <= sin_ff[1];
         // carry yaw along so it meets BD and AD of the same item
         e_ff <= cos_ff[2];
         f_ff <= sin_ff[2];

         bdhe_ff <= 47'(bdh * e_ff);
         bdle_ff <= 47'(bdl * e_ff);
         bdhf_ff <= 47'(bdh * f_ff);
         bdlf_ff <= 47'(bdl * f_ff);
         adhe_ff <= 47'(adh * e_ff);
         adle_ff <= 47'(adl * e_ff);
         adhf_ff <= 47'(adh * f_ff);
         adlf_ff <= 47'(adl * f_ff);
         ce2_ff <= ce_ff; cf2_ff <= cf_ff; af2_ff <= af_ff; ae2_ff <= ae_ff;
         bf2_ff <= bf_ff; be2_ff <= be_ff; bc2_ff <= bc_ff; ac2_ff <= ac_ff;
         d2_ff <= d_ff;

         v_ff[0] <= wide(47'(ce2_ff), 20);
         v_ff[1] <= -wide(47'(cf2_ff), 20);
         v_ff[2] <= -wide(47'(d2_ff), 40);
         v_ff[3] <= wide(47'(af2_ff), 20) - wide(bdhe_ff, 22) - wide(bdle_ff, 0);
         v_ff[4] <= wide(47'(ae2_ff), 20) + wide(bdhf_ff, 22) + wide(bdlf_ff, 0);
         v_ff[5] <= -wide(47'(bc2_ff), 20);
         v_ff[6] <= wide(47'(bf2_ff), 20) + wide(adhe_ff, 22) + wide(adle_ff, 0);
         v_ff[7] <= wide(47'(be2_ff), 20) - wide(adhf_ff, 22) - wide(adlf_ff, 0);
         v_ff[8] <= wide(47'(ac2_ff), 20);

         for (int i = 0; i < 9; i++) begin
            r_ff[i] <= to_q14(v_ff[i]);
         end
      end
   end

   assign r_o = r_ff;

endmodule

/* rtl/euler_to_rotation_matrix.sv */
// Euler angles (pitch, roll, yaw as binary angles, 2^ANGLE_BITS per turn) in,
// nine Q1.14 rotation matrix entries out, saturated to +-1.0. One item per
// clock through a chain of CORDIC_STEPS rotation cells per angle, then five
// stages of quadrant mapping, multiplies and rounding. The whole pipeline
// stalls only while a result waits at the output.
// Uses ertm_pkg, ertm_cordic_cell and ertm_matrix.
module euler_to_rotation_matrix
   import ertm_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pitch_angle[15:0], roll_angle[31:16], yaw_angle[47:32]
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22, 16 bits each from bit 0
   output logic [143:0] rsp_tdata
);

   localparam int LAT = CORDIC_STEPS + 5;
   localparam logic [15:0] IN_MASK =
      (ANGLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ANGLE_BITS) - 32'd1);
   localparam int SHIFT = 32 - ANGLE_BITS;

   logic adv;
   logic [LAT-1:0] vld_ff, vld_in;

   cxy_type x_w [3][CORDIC_STEPS+1];
   cxy_type y_w [3][CORDIC_STEPS+1];
   cz_type z_w [3][CORDIC_STEPS+1];
   logic [1:0] q_w [3][CORDIC_STEPS+1];
   cxy_type x_end [3], y_end [3];
   logic [1:0] q_end [3];
   q14_type r [9];

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   for (genvar a = 0; a < 3; a++) begin : g_angle
      logic [31:0] ang, t;
      assign ang = 32'(req_tdata[16*a +: 16] & IN_MASK) << SHIFT;
      // offset by 1/8 turn so the top bits pick the quadrant
      assign t = ang + 32'h20000000;
      assign q_w[a][0] = t[31:30];
      assign z_w[a][0] = cz_type'({2'b00, t[29:0]}) - EIGHTH_TURN;
      assign x_w[a][0] = INV_GAIN;
      assign y_w[a][0] = '0;

      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
         ertm_cordic_cell #(.STEP(s)) u_cell (
            .clock (clock),
            .adv   (adv),
            .x_i   (x_w[a][s]),
            .y_i   (y_w[a][s]),
            .z_i   (z_w[a][s]),
            .quad_i(q_w[a][s]),
            .x_o   (x_w[a][s+1]),
            .y_o   (y_w[a][s+1]),
            .z_o   (z_w[a][s+1]),
            .quad_o(q_w[a][s+1])
         );
      end

      assign x_end[a] = x_w[a][CORDIC_STEPS];
      assign y_end[a] = y_w[a][CORDIC_STEPS];
      assign q_end[a] = q_w[a][CORDIC_STEPS];
   end

   ertm_matrix u_matrix (
      .clock (clock),
      .adv   (adv),
      .x_i   (x_end),
      .y_i   (y_end),
      .quad_i(q_end),
      .r_o   (r)
   );

   always_comb begin
      vld_in = vld_ff;
      if (adv) begin
         vld_in = {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];

   for (genvar i = 0; i < 9; i++) begin : g_out
      assign rsp_tdata[16*i +: 16] = r[i];
   end

`ifndef SYNTHESIS
   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   a_item_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted item lost at pipe entry");

   a_r00_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16384 &&
                      $signed(rsp_tdata[15:0]) >= -16384))
      else $error("r00 outside +-1.0");

   a_r22_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[143:128]) <= 16384 &&
                      $signed(rsp_tdata[143:128]) >= -16384))
      else $error("r22 outside +-1.0");
`endif

endmodule
